[hw/rtl/qdd_pkg.sv]
// Shared types and constants for the quadrature detent decoder.
`default_nettype none
package qdd_pkg;

  localparam int DELAY_BITS_DEFAULT = 16;
  localparam int SETTLE_W           = 16;
  localparam int LIMIT_W            = 8;
  localparam int CODE_W             = 2;
  localparam int CFG_INDEX_W        = 3;
  localparam int CFG_DATA_W         = 16;

  localparam int STALL_LIMIT_RESET  = 15;

  localparam logic [SETTLE_W-1:0] SETTLE_RESET = SETTLE_W'(10);
  localparam logic [CODE_W-1:0]   IDLE_RESET   = 2'd3;
  localparam logic [CODE_W-1:0]   FREV_RESET   = 2'd1;
  localparam logic [CODE_W-1:0]   FFWD_RESET   = 2'd2;
  localparam logic [CODE_W-1:0]   MID_RESET    = 2'd0;
  localparam logic [CODE_W-1:0]   LREV_RESET   = 2'd2;
  localparam logic [CODE_W-1:0]   LFWD_RESET   = 2'd1;

  localparam logic signed [1:0] MOVE_NONE    = 2'sd0;
  localparam logic signed [1:0] MOVE_FORWARD = 2'sd1;
  localparam logic signed [1:0] MOVE_REVERSE = -2'sd1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SETTLE_TICKS  = 3'd0,
    REG_STALL_LIMIT   = 3'd1,
    REG_CODE_IDLE     = 3'd2,
    REG_FIRST_REVERSE = 3'd3,
    REG_FIRST_FORWARD = 3'd4,
    REG_CODE_MIDDLE   = 3'd5,
    REG_LAST_REVERSE  = 3'd6,
    REG_LAST_FORWARD  = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_WAIT   = 3'd0,
    PH_FIRST  = 3'd1,
    PH_MIDDLE = 3'd2,
    PH_LAST   = 3'd3,
    PH_RESET  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [SETTLE_W-1:0] settle_ticks;
    logic [LIMIT_W-1:0]  stall_limit;
    logic [CODE_W-1:0]   code_idle;
    logic [CODE_W-1:0]   code_first_reverse;
    logic [CODE_W-1:0]   code_first_forward;
    logic [CODE_W-1:0]   code_middle;
    logic [CODE_W-1:0]   code_last_reverse;
    logic [CODE_W-1:0]   code_last_forward;
  } cfg_t;

  typedef struct packed {
    logic signed [1:0] movement;
    logic [2:0]        phase;
  } result_t;

endpackage
`default_nettype wire

[hw/rtl/qdd_core.sv]
// Detent phase machine with settling delay and stall counter.
`default_nettype none
module qdd_core #(
  parameter int DELAY_BITS = qdd_pkg::DELAY_BITS_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        take,
  input  wire logic [qdd_pkg::CODE_W-1:0]  code,
  input  wire qdd_pkg::cfg_t               cfg,
  output qdd_pkg::result_t                 result
);
  import qdd_pkg::*;

  localparam int WIDE = (DELAY_BITS > SETTLE_W) ? DELAY_BITS : SETTLE_W;

  phase_t               phase_reg, phase_next;
  logic [CODE_W-1:0]    previous_code, previous_code_next;
  logic                 reverse_seen, reverse_seen_next;
  logic                 forward_seen, forward_seen_next;
  logic [LIMIT_W-1:0]   stall_count, stall_count_next;
  logic [DELAY_BITS-1:0] delay_left, delay_left_next;

  logic [WIDE-1:0]       settle_wide;
  logic [WIDE-1:0]       max_wide;
  logic [DELAY_BITS-1:0] reload_val;
  logic                  eval;
  logic                  changed;
  logic [LIMIT_W-1:0]    stall_inc;
  logic                  stall_over;
  logic signed [1:0]     move;

  assign settle_wide = WIDE'(cfg.settle_ticks);
  assign max_wide    = WIDE'({DELAY_BITS{1'b1}});
  assign reload_val  = (settle_wide > max_wide) ? max_wide[DELAY_BITS-1:0]
                                                : settle_wide[DELAY_BITS-1:0];
  assign eval        = (delay_left == '0);
  assign changed     = (code != previous_code);
  assign stall_inc   = (stall_count == {LIMIT_W{1'b1}}) ? stall_count
                                                        : stall_count + 1'b1;
  assign stall_over  = (stall_inc > cfg.stall_limit);

  // next state
  always_comb begin
    phase_next         = phase_reg;
    previous_code_next = previous_code;
    reverse_seen_next  = reverse_seen;
    forward_seen_next  = forward_seen;
    stall_count_next   = stall_count;
    delay_left_next    = delay_left;
    if (take) begin
      if (!eval) begin
        delay_left_next = delay_left - 1'b1;
      end else begin
        case (phase_reg)
          PH_WAIT: begin
            if (changed) begin
              if (code == cfg.code_first_reverse) begin
                phase_next        = PH_FIRST;
                reverse_seen_next = 1'b1;
              end else if (code == cfg.code_first_forward) begin
                phase_next        = PH_FIRST;
                forward_seen_next = 1'b1;
              end else begin
                phase_next        = PH_RESET;
                reverse_seen_next = 1'b0;
                forward_seen_next = 1'b0;
              end
              stall_count_next   = '0;
              previous_code_next = code;
              delay_left_next    = reload_val;
            end
          end
          PH_FIRST, PH_MIDDLE, PH_LAST: begin
            if (!changed) begin
              if (stall_over) begin
                stall_count_next  = '0;
                phase_next        = PH_RESET;
                reverse_seen_next = 1'b0;
                forward_seen_next = 1'b0;
              end else begin
                stall_count_next = stall_inc;
                delay_left_next  = reload_val;
              end
            end else begin
              stall_count_next   = '0;
              previous_code_next = code;
              if (phase_reg == PH_FIRST) begin
                delay_left_next = reload_val;
                if (code == cfg.code_middle) begin
                  phase_next = PH_MIDDLE;
                end else begin
                  phase_next        = PH_RESET;
                  reverse_seen_next = 1'b0;
                  forward_seen_next = 1'b0;
                end
              end else if (phase_reg == PH_MIDDLE) begin
                if (code == cfg.code_last_reverse) begin
                  if (reverse_seen) begin
                    phase_next      = PH_LAST;
                    delay_left_next = reload_val;
                  end
                end else if (code == cfg.code_last_forward) begin
                  if (forward_seen) begin
                    phase_next      = PH_LAST;
                    delay_left_next = reload_val;
                  end
                end else begin
                  phase_next        = PH_RESET;
                  reverse_seen_next = 1'b0;
                  forward_seen_next = 1'b0;
                end
              end else begin
                phase_next        = PH_WAIT;
                reverse_seen_next = 1'b0;
                forward_seen_next = 1'b0;
              end
            end
          end
          PH_RESET: begin
            if (changed) begin
              if (code == cfg.code_idle) begin
                phase_next = PH_WAIT;
              end
              previous_code_next = code;
            end
            delay_left_next = reload_val;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // outputs
  always_comb begin
    move = MOVE_NONE;
    if (take && eval && phase_reg == PH_LAST && changed) begin
      priority if (reverse_seen) begin
        move = MOVE_REVERSE;
      end else if (forward_seen) begin
        move = MOVE_FORWARD;
      end
    end
  end

  assign result.movement = move;
  assign result.phase    = phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg     <= PH_WAIT;
      previous_code <= '0;
      reverse_seen  <= 1'b0;
      forward_seen  <= 1'b0;
      stall_count   <= '0;
      delay_left    <= '0;
    end else begin
      phase_reg     <= phase_next;
      previous_code <= previous_code_next;
      reverse_seen  <= reverse_seen_next;
      forward_seen  <= forward_seen_next;
      stall_count   <= stall_count_next;
      delay_left    <= delay_left_next;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/quadrature_detent_decoder.sv]
// Quadrature detent decoder top level: config registers and result buffer.
//
// Sample channel: one request per tick carries pin_code (bit1 channel A,
// bit0 channel B), taken when sample_valid is high and sample_stall low.
// Result channel: one result per request, movement (+1 forward, -1
// reverse, 0 none) and phase after that tick, taken when result_valid is
// high and result_stall low.
// Each result is registered before it is offered. Throughput: one request
// per cycle while sample_stall is low; the phase machine and settling
// counter update combinationally from the register state.
// Backpressure: an output register plus one skid register; sample_stall
// rises only when both hold results, so one more request is taken while a
// result waits at the output.
// Config: cfg_we writes cfg_data to register cfg_index at once; write only
// while no results are pending.
// Reset (rst, synchronous): registers go to their defaults, phase to wait,
// settling delay to expired, both result slots empty.
`default_nettype none
module quadrature_detent_decoder #(
  parameter int DELAY_BITS = qdd_pkg::DELAY_BITS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             sample_valid,
  output logic                                  sample_stall,
  input  wire logic [qdd_pkg::CODE_W-1:0]       pin_code,
  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output logic signed [1:0]                     movement,
  output logic [2:0]                            phase,
  input  wire logic                             cfg_we,
  input  wire logic [qdd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [qdd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import qdd_pkg::*;

  cfg_t    cfg;
  result_t new_result;
  result_t out_data, skid_data;
  logic    out_full, skid_full;
  logic    take, pop;

  assign sample_stall = skid_full;
  assign take         = sample_valid && !skid_full;
  assign pop          = out_full && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_ticks       <= SETTLE_RESET;
      cfg.stall_limit        <= LIMIT_W'(STALL_LIMIT_RESET);
      cfg.code_idle          <= IDLE_RESET;
      cfg.code_first_reverse <= FREV_RESET;
      cfg.code_first_forward <= FFWD_RESET;
      cfg.code_middle        <= MID_RESET;
      cfg.code_last_reverse  <= LREV_RESET;
      cfg.code_last_forward  <= LFWD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SETTLE_TICKS:  cfg.settle_ticks       <= cfg_data[SETTLE_W-1:0];
        REG_STALL_LIMIT:   cfg.stall_limit        <= cfg_data[LIMIT_W-1:0];
        REG_CODE_IDLE:     cfg.code_idle          <= cfg_data[CODE_W-1:0];
        REG_FIRST_REVERSE: cfg.code_first_reverse <= cfg_data[CODE_W-1:0];
        REG_FIRST_FORWARD: cfg.code_first_forward <= cfg_data[CODE_W-1:0];
        REG_CODE_MIDDLE:   cfg.code_middle        <= cfg_data[CODE_W-1:0];
        REG_LAST_REVERSE:  cfg.code_last_reverse  <= cfg_data[CODE_W-1:0];
        REG_LAST_FORWARD:  cfg.code_last_forward  <= cfg_data[CODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  qdd_core #(
    .DELAY_BITS(DELAY_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .take   (take),
    .code   (pin_code),
    .cfg    (cfg),
    .result (new_result)
  );

  // result buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full  <= 1'b0;
      skid_full <= 1'b0;
    end else if (out_full && !pop) begin
      if (take) begin
        skid_full <= 1'b1;
      end
    end else if (skid_full) begin
      out_full  <= 1'b1;
      skid_full <= 1'b0;
    end else begin
      out_full <= take;
    end
  end

  // result buffer data
  always_ff @(posedge clk) begin
    if (out_full && !pop) begin
      if (take) begin
        skid_data <= new_result;
      end
    end else if (skid_full) begin
      out_data <= skid_data;
    end else if (take) begin
      out_data <= new_result;
    end
  end

  assign result_valid = out_full;
  assign movement     = out_data.movement;
  assign phase        = out_data.phase;

endmodule
`default_nettype wire

[hw/rtl/qdd_checker.sv]
// Port-level checks for the quadrature detent decoder, bound to the top level.
`default_nettype none
module qdd_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             sample_stall,
  input wire logic                             result_valid,
  input wire logic                             result_stall,
  input wire logic signed [1:0]                movement,
  input wire logic [2:0]                       phase
);
  import qdd_pkg::*;

  // a completed detent always lands in wait
  assert property (@(posedge clk) disable iff (rst)
    result_valid && movement != MOVE_NONE |-> phase == PH_WAIT)
    else $error("detent reported outside wait phase");

  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> movement != 2'sb10)
    else $error("movement out of range");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(movement) && $stable(phase))
    else $error("stalled result changed");

  // backpressure appears only after a result was held at the output
  assert property (@(posedge clk) disable iff (rst)
    $rose(sample_stall) |-> $past(result_valid && result_stall))
    else $error("request stalled without a held result");

  assert property (@(posedge clk)
    rst |=> !result_valid && !sample_stall)
    else $error("result buffer not empty after reset");

endmodule

bind quadrature_detent_decoder qdd_checker u_qdd_checker (.*);
`default_nettype wire
